// ===== hw/rtl/i2cmrt_pkg.sv =====
// Shared types and codes of the I2C master register transaction sequencer.
package i2cmrt_pkg;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_BEGIN  = 2'd1,
        FN_MASTER = 2'd2,
        FN_SLAVE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_WDEV    = 4'd2,
        PH_MEM     = 4'd3,
        PH_RESTART = 4'd4,
        PH_RDEV    = 4'd5,
        PH_RDATA   = 4'd6,
        PH_ACK     = 4'd7,
        PH_NACK    = 4'd8,
        PH_STOP    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_ACK     = 3'd4,
        CMD_NACK    = 3'd5,
        CMD_RXEN    = 3'd6,
        CMD_SEND    = 3'd7
    } cmd_t;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    // Payload of an input beat, last field in the lowest bits.
    typedef struct packed {
        logic [7:0] received_byte;
        logic       receive_busy;
        logic       shift_busy;
        logic [7:0] read_count;
        logic [4:0] write_count;
        logic [7:0] register_addr;
        logic [7:0] target_addr;
        logic [7:0] tx_data;
        logic [3:0] buf_index;
    } in_data_t;

    typedef struct packed {
        func_t    func;
        in_data_t data;
    } in_item_t;

    // Payload of a result beat, last field in the lowest bits.
    typedef struct packed {
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] send_byte;
        cmd_t       bus_cmd;
    } result_t;

endpackage

// ===== hw/rtl/i2cmrt_in_reg.sv =====
// Input register stage that holds one accepted beat until it is processed.
module i2cmrt_in_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cmrt_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                          s_tuser,
    input  logic                                adv,
    output logic                                in_vld,
    output i2cmrt_pkg::in_item_t                item
);
    import i2cmrt_pkg::*;

    localparam int DW = $bits(in_data_t);

    logic     in_vld_reg;
    in_item_t item_reg;

    // The register frees up in the same cycle its beat moves on.
    assign s_tready = ~in_vld_reg | adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.func <= func_t'(s_tuser);
            item_reg.data <= in_data_t'(s_tdata[DW-1:0]);
        end
    end

    assign in_vld = in_vld_reg;
    assign item   = item_reg;

endmodule

// ===== hw/rtl/i2cmrt_step.sv =====
// Transaction state, transmit buffer and the per-beat sequencing logic.
module i2cmrt_step #(
    parameter int TX_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  i2cmrt_pkg::in_item_t  item,
    output i2cmrt_pkg::result_t   res
);
    import i2cmrt_pkg::*;

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    phase_t     phase_reg, phase_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] regaddr_reg, regaddr_next;
    logic [4:0] writes_left_reg, writes_left_next;
    logic [7:0] reads_left_reg, reads_left_next;
    logic [AW-1:0] tx_pos_reg, tx_pos_next;
    logic [7:0] rx_pos_reg, rx_pos_next;

    logic [7:0]    mem [TX_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          in_range;
    logic          is_master;
    in_data_t      d;

    assign d         = item.data;
    assign is_master = (item.func == FN_MASTER);
    assign in_range  = ({28'd0, d.buf_index} < TX_DEPTH);
    assign mem_waddr = AW'(d.buf_index);

    always_comb begin
        phase_next       = phase_reg;
        dev_next         = dev_reg;
        regaddr_next     = regaddr_reg;
        writes_left_next = writes_left_reg;
        reads_left_next  = reads_left_reg;
        tx_pos_next      = tx_pos_reg;
        rx_pos_next      = rx_pos_reg;
        mem_we           = 1'b0;
        res              = '0;
        res.bus_cmd      = CMD_NONE;
        if (adv) begin
            case (item.func)
                FN_LOAD: begin
                    mem_we = in_range;
                end
                FN_BEGIN: begin
                    // A begin while busy only latches its values.
                    dev_next         = d.target_addr;
                    regaddr_next     = d.register_addr;
                    writes_left_next = d.write_count;
                    reads_left_next  = d.read_count;
                    tx_pos_next      = '0;
                    rx_pos_next      = '0;
                    if (phase_reg == PH_IDLE) begin
                        res.bus_cmd = CMD_START;
                        phase_next  = PH_START;
                    end
                end
                FN_MASTER, FN_SLAVE: begin
                    case (phase_reg)
                        PH_STOP: begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        PH_RDEV: begin
                            if (!d.shift_busy) begin
                                res.bus_cmd = CMD_RXEN;
                                phase_next  = PH_RDATA;
                            end
                        end
                        PH_RDATA: begin
                            if (reads_left_reg == 8'd0) begin
                                res.bus_cmd = CMD_STOP;
                                phase_next  = PH_STOP;
                            end else if (!d.receive_busy) begin
                                res.rx_valid    = 1'b1;
                                res.rx_byte     = d.received_byte;
                                res.rx_index    = rx_pos_reg;
                                rx_pos_next     = rx_pos_reg + 8'd1;
                                reads_left_next = reads_left_reg - 8'd1;
                                if (reads_left_reg == 8'd1) begin
                                    res.bus_cmd = CMD_NACK;
                                    phase_next  = PH_NACK;
                                end else begin
                                    res.bus_cmd = CMD_ACK;
                                    phase_next  = PH_ACK;
                                end
                            end
                        end
                        PH_ACK: begin
                            res.bus_cmd = CMD_RXEN;
                            phase_next  = PH_RDATA;
                        end
                        PH_NACK: begin
                            res.bus_cmd = CMD_STOP;
                            phase_next  = PH_STOP;
                        end
                        PH_START: begin
                            if (is_master) begin
                                res.bus_cmd   = CMD_SEND;
                                res.send_byte = {dev_reg[7:1], 1'b0};
                                phase_next    = PH_WDEV;
                            end
                        end
                        PH_WDEV: begin
                            if (is_master && !d.shift_busy) begin
                                res.bus_cmd   = CMD_SEND;
                                res.send_byte = regaddr_reg;
                                phase_next    = PH_MEM;
                            end
                        end
                        PH_MEM: begin
                            if (is_master && !d.shift_busy) begin
                                if (writes_left_reg != 5'd0) begin
                                    res.bus_cmd      = CMD_SEND;
                                    res.send_byte    = rd_data_reg;
                                    writes_left_next = writes_left_reg - 5'd1;
                                    if (tx_pos_reg == AW'(TX_DEPTH - 1)) begin
                                        tx_pos_next = '0;
                                    end else begin
                                        tx_pos_next = tx_pos_reg + AW'(1);
                                    end
                                end else if (reads_left_reg != 8'd0) begin
                                    res.bus_cmd = CMD_RESTART;
                                    phase_next  = PH_RESTART;
                                end else begin
                                    res.bus_cmd = CMD_STOP;
                                    phase_next  = PH_STOP;
                                end
                            end
                        end
                        PH_RESTART: begin
                            if (is_master) begin
                                res.bus_cmd   = CMD_SEND;
                                res.send_byte = {dev_reg[7:1], 1'b1};
                                phase_next    = PH_RDEV;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            dev_reg         <= '0;
            regaddr_reg     <= '0;
            writes_left_reg <= '0;
            reads_left_reg  <= '0;
            tx_pos_reg      <= '0;
            rx_pos_reg      <= '0;
        end else begin
            phase_reg       <= phase_next;
            dev_reg         <= dev_next;
            regaddr_reg     <= regaddr_next;
            writes_left_reg <= writes_left_next;
            reads_left_reg  <= reads_left_next;
            tx_pos_reg      <= tx_pos_next;
            rx_pos_reg      <= rx_pos_next;
        end
    end

    // The buffer is read one beat ahead at the position the next send will use;
    // a load to that same slot is forwarded so the prefetched byte stays current.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= d.tx_data;
        end
        if (mem_we && (mem_waddr == tx_pos_next)) begin
            rd_data_reg <= d.tx_data;
        end else begin
            rd_data_reg <= mem[tx_pos_next];
        end
    end

endmodule

// ===== hw/rtl/i2cmrt_out_reg.sv =====
// Result register that holds one result beat until the sink takes it.
module i2cmrt_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_vld,
    output logic                               adv,
    input  i2cmrt_pkg::result_t                res,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2cmrt_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import i2cmrt_pkg::*;

    localparam int RW = $bits(result_t);

    logic    out_vld_reg;
    result_t res_reg;

    // A beat is processed whenever the result register is empty or draining.
    assign adv = in_vld & (~out_vld_reg | m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (~out_vld_reg | m_tready) begin
            out_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W - RW){1'b0}}, res_reg};

endmodule

// ===== hw/rtl/i2c_master_register_transaction_top.sv =====
// Top level of the I2C master register transaction sequencer.
//
//  Channel  Direction  Payload
//  s_       in         tuser: func; tdata: load, begin and bus event fields
//  m_       out        tdata: bus command, send byte, received byte, status
//
// Every input beat yields exactly one result beat; it passes the input register, then the result register.
// A new beat is taken every cycle unless the result side stalls; the sequencing step is a single registered pass.
// Reset is synchronous; the transmit buffer is not cleared and holds unknown
// bytes until loaded. A stalled result register holds its beat and back-pressures
// the input only once the input register is also full.
module i2c_master_register_transaction_top #(
    parameter int TX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // buf_index[3:0], tx_data[11:4], target_addr[19:12], register_addr[27:20],
    // write_count[32:28], read_count[40:33], shift_busy[41], receive_busy[42],
    // received_byte[50:43], zero fill[55:51]
    input  logic [55:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_cmd[2:0], send_byte[10:3], rx_valid[11], rx_byte[19:12],
    // rx_index[27:20], done_res[28], busy_res[29], zero fill[31:30]
    output logic [31:0] m_tdata
);
    import i2cmrt_pkg::*;

    logic     in_vld;
    logic     adv;
    in_item_t item;
    result_t  res;

    i2cmrt_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .in_vld   (in_vld),
        .item     (item)
    );

    i2cmrt_step #(
        .TX_DEPTH (TX_DEPTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (item),
        .res     (res)
    );

    i2cmrt_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld),
        .adv      (adv),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/tb_i2c_master_register_transaction_top.sv =====
// Self-checking testbench for the I2C master register transaction sequencer.
`timescale 1ns / 100ps

module tb_i2c_master_register_transaction_top;
    import i2cmrt_pkg::*;

    localparam int TX_DEPTH       = 16;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        in_item_t it;
        bit       typed;
        result_t  want;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // buf_index[3:0], tx_data[11:4], target_addr[19:12], register_addr[27:20],
    // write_count[32:28], read_count[40:33], shift_busy[41], receive_busy[42],
    // received_byte[50:43], zero fill[55:51]
    logic [55:0] s_tdata;
    // func[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // bus_cmd[2:0], send_byte[10:3], rx_valid[11], rx_byte[19:12],
    // rx_index[27:20], done_res[28], busy_res[29], zero fill[31:30]
    logic [31:0] m_tdata;

    // Shadow copy of the sequencer state.
    phase_t     seq_phase;
    logic [7:0] target_shadow;
    logic [7:0] reg_addr;
    logic [4:0] writes_pending;
    logic [7:0] reads_pending;
    logic [3:0] tx_slot;
    logic [7:0] rx_count;
    logic [7:0] tx_buf [TX_DEPTH];
    logic [TX_DEPTH-1:0] slot_loaded;

    result_t       pending_steps [$];
    directed_row_t plan [$];
    int            mismatches;
    int            sender_idle_pct;
    int            stall_pct;
    bit            holdoff_req;
    int            quiet_cycles;

    i2c_master_register_transaction_top #(
        .TX_DEPTH (TX_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // One sequencing step: updates the shadow state and returns the result beat.
    function automatic result_t sequencer_step(in_item_t it);
        result_t r;
        logic    on_read_side;
        r = '0;
        on_read_side = 1'b0;
        case (it.func)
            FN_LOAD: begin
                if (int'(it.data.buf_index) < TX_DEPTH) begin
                    tx_buf[it.data.buf_index] = it.data.tx_data;
                    slot_loaded[it.data.buf_index] = 1'b1;
                end
            end
            FN_BEGIN: begin
                // Values are latched even mid-transaction; only an idle block starts.
                target_shadow = it.data.target_addr;
                reg_addr = it.data.register_addr;
                writes_pending = it.data.write_count;
                reads_pending = it.data.read_count;
                tx_slot = '0;
                rx_count = '0;
                if (seq_phase == PH_IDLE) begin
                    r.bus_cmd = CMD_START;
                    seq_phase = PH_START;
                end
            end
            default: begin
                on_read_side = 1'b1;
                case (seq_phase)
                    PH_STOP: begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                    PH_RDEV: begin
                        if (!it.data.shift_busy) begin
                            r.bus_cmd = CMD_RXEN;
                            seq_phase = PH_RDATA;
                        end
                    end
                    PH_RDATA: begin
                        if (reads_pending == 8'd0) begin
                            r.bus_cmd = CMD_STOP;
                            seq_phase = PH_STOP;
                        end else if (!it.data.receive_busy) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = it.data.received_byte;
                            r.rx_index = rx_count;
                            rx_count = rx_count + 8'd1;
                            if (reads_pending == 8'd1) begin
                                r.bus_cmd = CMD_NACK;
                                seq_phase = PH_NACK;
                            end else begin
                                r.bus_cmd = CMD_ACK;
                                seq_phase = PH_ACK;
                            end
                            reads_pending = reads_pending - 8'd1;
                        end
                    end
                    PH_ACK: begin
                        r.bus_cmd = CMD_RXEN;
                        seq_phase = PH_RDATA;
                    end
                    PH_NACK: begin
                        r.bus_cmd = CMD_STOP;
                        seq_phase = PH_STOP;
                    end
                    default: on_read_side = 1'b0;
                endcase
                // Write-side phases move only on master events.
                if (!on_read_side && it.func == FN_MASTER) begin
                    case (seq_phase)
                        PH_START: begin
                            r.bus_cmd = CMD_SEND;
                            r.send_byte = target_shadow & 8'hFE;
                            seq_phase = PH_WDEV;
                        end
                        PH_WDEV: begin
                            if (!it.data.shift_busy) begin
                                r.bus_cmd = CMD_SEND;
                                r.send_byte = reg_addr;
                                seq_phase = PH_MEM;
                            end
                        end
                        PH_MEM: begin
                            if (!it.data.shift_busy) begin
                                if (writes_pending != 5'd0) begin
                                    r.bus_cmd = CMD_SEND;
                                    r.send_byte = tx_buf[tx_slot];
                                    tx_slot = tx_slot + 4'd1;
                                    writes_pending = writes_pending - 5'd1;
                                end else if (reads_pending != 8'd0) begin
                                    r.bus_cmd = CMD_RESTART;
                                    seq_phase = PH_RESTART;
                                end else begin
                                    r.bus_cmd = CMD_STOP;
                                    seq_phase = PH_STOP;
                                end
                            end
                        end
                        PH_RESTART: begin
                            r.bus_cmd = CMD_SEND;
                            r.send_byte = target_shadow | 8'h01;
                            seq_phase = PH_RDEV;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    // Mostly well-formed transactions with random content, plus loads, restarts
    // of the latched values and events that the current phase ignores.
    function automatic in_item_t random_step_item();
        logic [63:0] raw;
        in_item_t    it;
        int          roll;
        int          size_roll;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        roll = $urandom_range(99);
        size_roll = $urandom_range(99);
        it.data.shift_busy = ($urandom_range(99) < 25);
        it.data.receive_busy = ($urandom_range(99) < 25);
        if (seq_phase == PH_IDLE) begin
            if (roll < 15) begin
                it.func = FN_LOAD;
            end else if (roll < 22) begin
                it.func = $urandom_range(1) ? FN_MASTER : FN_SLAVE;
            end else begin
                it.func = FN_BEGIN;
                if (size_roll < 85)
                    it.data.write_count = 5'($urandom_range(0, 4));
                else if (size_roll < 95)
                    it.data.write_count = 5'd16;
                else
                    it.data.write_count = 5'($urandom_range(17, 31));
                size_roll = $urandom_range(99);
                if (size_roll < 2)
                    it.data.read_count = 8'd255;
                else if (size_roll < 8)
                    it.data.read_count = 8'($urandom_range(6, 40));
                else
                    it.data.read_count = 8'($urandom_range(0, 5));
            end
        end else if (roll < 5) begin
            it.func = FN_LOAD;
        end else if (roll < 8) begin
            it.func = FN_BEGIN;
            it.data.write_count = 5'($urandom_range(0, 3));
            it.data.read_count = 8'($urandom_range(0, 3));
        end else if (seq_phase inside {PH_START, PH_WDEV, PH_MEM, PH_RESTART}) begin
            it.func = (roll < 92) ? FN_MASTER : FN_SLAVE;
        end else begin
            it.func = roll[0] ? FN_MASTER : FN_SLAVE;
        end
        // Never send a data byte from a slot that was never loaded: load it first.
        if (it.func == FN_MASTER && seq_phase == PH_MEM && !it.data.shift_busy &&
            writes_pending != 5'd0 && !slot_loaded[tx_slot]) begin
            it.func = FN_LOAD;
            it.data.buf_index = tx_slot;
        end
        return it;
    endfunction

    function automatic in_item_t load_beat(logic [3:0] slot, logic [7:0] value);
        in_item_t it;
        it = '0;
        it.func = FN_LOAD;
        it.data.buf_index = slot;
        it.data.tx_data = value;
        return it;
    endfunction

    function automatic in_item_t begin_beat(logic [7:0] tgt, logic [7:0] regad,
                                            logic [4:0] wcnt, logic [7:0] rcnt);
        in_item_t it;
        it = '0;
        it.func = FN_BEGIN;
        it.data.target_addr = tgt;
        it.data.register_addr = regad;
        it.data.write_count = wcnt;
        it.data.read_count = rcnt;
        return it;
    endfunction

    function automatic in_item_t event_beat(func_t f, logic sbusy, logic rbusy,
                                            logic [7:0] rbyte);
        in_item_t it;
        it = '0;
        it.func = f;
        it.data.shift_busy = sbusy;
        it.data.receive_busy = rbusy;
        it.data.received_byte = rbyte;
        return it;
    endfunction

    function automatic result_t plain_result(cmd_t cmd, logic [7:0] sbyte,
                                             logic done, logic busy);
        result_t r;
        r = '0;
        r.bus_cmd = cmd;
        r.send_byte = sbyte;
        r.done_res = done;
        r.busy_res = busy;
        return r;
    endfunction

    task automatic offer(input in_item_t it, input bit typed, input result_t want);
        result_t predicted;
        int      idle;
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {5'b0, it.data};
        do @(posedge aclk); while (!s_tready);
        predicted = sequencer_step(it);
        pending_steps.push_back(typed ? want : predicted);
        idle = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
            idle++;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side ready; a requested hold-off keeps it low long enough to fill
    // the block and back-pressure the input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_req = 1'b0;
            end
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (pending_steps.size() == 0) begin
                $error("result beat with no step outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_steps.pop_front();
                check_field("bus_cmd", want.bus_cmd, got.bus_cmd);
                check_field("send_byte", want.send_byte, got.send_byte);
                check_field("rx_valid", want.rx_valid, got.rx_valid);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("rx_index", want.rx_index, got.rx_index);
                check_field("done_res", want.done_res, got.done_res);
                check_field("busy_res", want.busy_res, got.busy_res);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("i2c_master_register_transaction_top verification failed");
            $finish;
        end
    end

    initial begin
        int count;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= FN_LOAD;
        s_tdata <= '0;
        seq_phase = PH_IDLE;
        target_shadow = '0;
        reg_addr = '0;
        writes_pending = '0;
        reads_pending = '0;
        tx_slot = '0;
        rx_count = '0;
        slot_loaded = '0;
        mismatches = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        holdoff_req = 1'b0;

        // Idle events do nothing, a busy begin only relatches; then one transaction.
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b1,
                         plain_result(CMD_NONE, 8'h00, 0, 0)});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b1,
                         plain_result(CMD_NONE, 8'h00, 0, 0)});
        plan.push_back('{load_beat(4'd0, 8'hFF), 1'b1, plain_result(CMD_NONE, 8'h00, 0, 0)});
        plan.push_back('{load_beat(4'd15, 8'h00), 1'b1, plain_result(CMD_NONE, 8'h00, 0, 0)});
        plan.push_back('{load_beat(4'd1, 8'hA5), 1'b0, '0});
        plan.push_back('{begin_beat(8'h00, 8'h00, 5'd0, 8'd0), 1'b1,
                         plain_result(CMD_START, 8'h00, 0, 1)});
        plan.push_back('{begin_beat(8'h00, 8'hFF, 5'd31, 8'd255), 1'b1,
                         plain_result(CMD_NONE, 8'h00, 0, 1)});
        plan.push_back('{begin_beat(8'hFF, 8'h5A, 5'd2, 8'd2), 1'b1,
                         plain_result(CMD_NONE, 8'h00, 0, 1)});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b1,
                         plain_result(CMD_SEND, 8'hFE, 0, 1)});
        plan.push_back('{event_beat(FN_MASTER, 1, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 1, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 1, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 0, 1, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'hFF), 1'b0, '0});
        plan.push_back('{event_beat(FN_SLAVE, 0, 0, 8'h00), 1'b0, '0});
        plan.push_back('{event_beat(FN_MASTER, 0, 0, 8'h00), 1'b1,
                         plain_result(CMD_NONE, 8'h00, 1, 0)});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            offer(plan[i].it, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 5; ph++) begin
            count = 100;
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                    count = 120;
                end
                1: begin
                    sender_idle_pct = 62;
                    stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct = 62;
                end
                3: begin
                    sender_idle_pct = 29;
                    stall_pct = 29;
                end
                default: begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                    holdoff_req = 1'b1;
                    count = 40;
                end
            endcase
            for (int n = 0; n < count; n++)
                offer(random_step_item(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (pending_steps.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("i2c_master_register_transaction_top verification clean");
        else
            $display("i2c_master_register_transaction_top verification failed");
        $finish;
    end

endmodule

// ===== i2c_master_register_transaction_top.f =====
hw/rtl/i2cmrt_pkg.sv
hw/rtl/i2cmrt_in_reg.sv
hw/rtl/i2cmrt_step.sv
hw/rtl/i2cmrt_out_reg.sv
hw/rtl/i2c_master_register_transaction_top.sv
tb/tb_i2c_master_register_transaction_top.sv
